// File: hw/rtl/mmu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// mmu_pkg: shared types and constants of the multiword multiplier
// Limb widths, command codes and the request/response words of the
// 64x64 multiply-accumulate unit.
// -----------------------------------------------------------------------------
package mmu_pkg;

	localparam int LIMB_W        = 64;
	localparam int HALF_W        = LIMB_W / 2;
	localparam int MAX_WORDS_DEF = 32;

	// Command codes carried on the op port.
	localparam logic [1:0] OP_APPEND_A = 2'd0;
	localparam logic [1:0] OP_APPEND_B = 2'd1;
	localparam logic [1:0] OP_MULTIPLY = 2'd2;

	// Request to the multiply-accumulate unit: x*y + addend + carry.
	typedef struct packed {
		logic              go;
		logic [LIMB_W-1:0] x;
		logic [LIMB_W-1:0] y;
		logic [LIMB_W-1:0] addend;
		logic [LIMB_W-1:0] carry;
	} mac_req_t;

	// Response: 128-bit result split into low and high limbs.
	typedef struct packed {
		logic              done;
		logic [LIMB_W-1:0] lo;
		logic [LIMB_W-1:0] hi;
	} mac_rsp_t;

endpackage
`default_nettype wire

// File: hw/rtl/mmu_mac.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// mmu_mac: iterative 64x64 multiply-accumulate
// Forms x*y + addend + carry as 128 bits with one 32x32 multiplier, one
// partial product per cycle, registered and added to a 128-bit accumulator.
// -----------------------------------------------------------------------------
module mmu_mac
	import mmu_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire mac_req_t req,
	output mac_rsp_t      rsp
);

	localparam int STEPS  = 4;
	localparam int STEP_W = $clog2(STEPS + 1);
	localparam int ACC_W  = 2 * LIMB_W;
	localparam int SH_W   = $clog2(ACC_W);

	logic [LIMB_W-1:0] x_q;
	logic [LIMB_W-1:0] y_q;
	logic [ACC_W-1:0]  acc_q;
	logic [LIMB_W-1:0] pp_q;
	logic [SH_W-1:0]   sh_q;
	logic              pp_v_q;
	logic [STEP_W-1:0] cnt_q;
	logic              active_q;
	logic              done_q;

	logic [HALF_W-1:0] mul_x;
	logic [HALF_W-1:0] mul_y;
	logic [SH_W-1:0]   sh_d;
	logic [LIMB_W-1:0] pp_d;

	// Partial product order: low*low, low*high, high*low, high*high.
	always_comb begin
		unique case (cnt_q)
			STEP_W'(0): begin
				mul_x = x_q[HALF_W-1:0];
				mul_y = y_q[HALF_W-1:0];
				sh_d  = SH_W'(0);
			end
			STEP_W'(1): begin
				mul_x = x_q[HALF_W-1:0];
				mul_y = y_q[LIMB_W-1:HALF_W];
				sh_d  = SH_W'(HALF_W);
			end
			STEP_W'(2): begin
				mul_x = x_q[LIMB_W-1:HALF_W];
				mul_y = y_q[HALF_W-1:0];
				sh_d  = SH_W'(HALF_W);
			end
			STEP_W'(3): begin
				mul_x = x_q[LIMB_W-1:HALF_W];
				mul_y = y_q[LIMB_W-1:HALF_W];
				sh_d  = SH_W'(LIMB_W);
			end
			default: begin
				mul_x = '0;
				mul_y = '0;
				sh_d  = '0;
			end
		endcase
	end

	assign pp_d = mul_x * mul_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			pp_v_q   <= 1'b0;
			cnt_q    <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				active_q <= 1'b1;
				pp_v_q   <= 1'b0;
				cnt_q    <= '0;
			end else if (active_q) begin
				pp_v_q <= (cnt_q != STEP_W'(STEPS));
				if (cnt_q != STEP_W'(STEPS)) begin
					cnt_q <= cnt_q + STEP_W'(1);
				end else begin
					active_q <= 1'b0;
					done_q   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			x_q   <= req.x;
			y_q   <= req.y;
			acc_q <= {{LIMB_W{1'b0}}, req.addend} + {{LIMB_W{1'b0}}, req.carry};
		end else if (active_q) begin
			pp_q <= pp_d;
			sh_q <= sh_d;
			if (pp_v_q) begin
				acc_q <= acc_q + ({{LIMB_W{1'b0}}, pp_q} << sh_q);
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.lo   = acc_q[LIMB_W-1:0];
	assign rsp.hi   = acc_q[ACC_W-1:LIMB_W];

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("mac done held for more than one cycle");
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		req.go |-> !active_q)
		else $error("mac started while a multiply was in progress");
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (cnt_q <= STEP_W'(STEPS)))
		else $error("mac step counter out of range");

endmodule
`default_nettype wire

// File: hw/rtl/multiword_multiplier_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// multiword_multiplier_unit: unsigned big-integer multiplier over 64-bit limbs
// Operands are appended limb by limb into two memories; a multiply command
// runs a schoolbook product into a product memory and streams the limbs out.
// -----------------------------------------------------------------------------
//
//  Channel   Handshake                  Payload
//  -------   -------------------------  -----------------------------------
//  command   start / busy (in, out)     op[1:0], limb[63:0]
//  result    strobe (out, one cycle)    product_limb[63:0], last_limb,
//                                       overflow
//
// A command word is taken at a rising edge with start high and busy low.
// Append words (op 0 or 1) leave busy low, so appends can follow back to
// back. A multiply with na and nb limbs keeps busy high while it works: for
// each limb pair it reads the B and product memories, starts the shared
// multiply-accumulate unit and waits while it walks the four 32x32 partial
// products; each row also reads A first and writes its carry last, and the
// result walk over the na + nb product limbs follows.
// With one operand empty the multiply is only the walk over na + nb zero
// limbs, and with both empty it finishes in its accept cycle with no results.
// Results come one per cycle, each word on the ports for one cycle with
// strobe high; the receiver cannot stall. Reset clears the counts and the
// overflow flag; the limb memories hold no reset value and need no clearing.
//
module multiword_multiplier_unit
	import mmu_pkg::*;
#(
	parameter int MAX_WORDS = MAX_WORDS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [1:0]        op,
	input  wire logic [LIMB_W-1:0] limb,
	output logic                   strobe,
	output logic [LIMB_W-1:0]      product_limb,
	output logic                   last_limb,
	output logic                   overflow
);

	localparam int AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
	localparam int CW = $clog2(MAX_WORDS + 1);
	localparam int PD = 2 * MAX_WORDS;
	localparam int PW = $clog2(PD);
	localparam int NW = $clog2(PD + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD_A,
		ST_RD_B,
		ST_MAC_GO,
		ST_MAC_WAIT,
		ST_WR_CARRY,
		ST_EMIT
	} state_t;

	state_t            state_q;
	logic [CW-1:0]     count_a_q;
	logic [CW-1:0]     count_b_q;
	logic              dropped_q;
	logic              zero_q;
	logic [AW-1:0]     i_q;
	logic [AW-1:0]     j_q;
	logic [PW-1:0]     k_q;
	logic [LIMB_W-1:0] carry_q;
	logic              strobe_s1;
	logic              last_s1;
	logic              overflow_s1;
	logic              zero_s1;

	// Operand and product memories, read data registered.
	logic [LIMB_W-1:0] mem_a [MAX_WORDS];
	logic [LIMB_W-1:0] mem_b [MAX_WORDS];
	logic [LIMB_W-1:0] mem_p [PD];
	logic [LIMB_W-1:0] a_rd_q;
	logic [LIMB_W-1:0] b_rd_q;
	logic [LIMB_W-1:0] p_rd_q;

	logic              accept;
	logic              a_room;
	logic              b_room;
	logic              a_we;
	logic              b_we;
	logic              p_we;
	logic              p_re;
	logic [PW-1:0]     p_waddr;
	logic [PW-1:0]     p_raddr;
	logic [LIMB_W-1:0] p_wdata;
	logic [PW-1:0]     addr_ij;
	logic [PW-1:0]     addr_inb;
	logic [NW-1:0]     n_limbs;
	logic              last_i;
	logic              last_j;
	logic              last_k;

	mac_req_t mac_req;
	mac_rsp_t mac_rsp;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign a_room = (count_a_q < CW'(MAX_WORDS));
	assign b_room = (count_b_q < CW'(MAX_WORDS));
	assign a_we   = accept && (op == OP_APPEND_A) && a_room;
	assign b_we   = accept && (op == OP_APPEND_B) && b_room;

	assign addr_ij  = PW'(i_q) + PW'(j_q);
	assign addr_inb = PW'(i_q) + PW'(count_b_q);
	assign n_limbs  = NW'(count_a_q) + NW'(count_b_q);
	assign last_i   = (CW'(i_q) == count_a_q - CW'(1));
	assign last_j   = (CW'(j_q) == count_b_q - CW'(1));
	assign last_k   = (NW'(k_q) == n_limbs - NW'(1));

	// Row i overwrites product limb i+j with the new partial sum and closes
	// the row by writing its carry to limb i+nb. Row 0 starts from zero, so
	// the product memory never needs a clearing pass.
	always_comb begin
		p_we    = 1'b0;
		p_waddr = addr_ij;
		p_wdata = mac_rsp.lo;
		if ((state_q == ST_MAC_WAIT) && mac_rsp.done) begin
			p_we = 1'b1;
		end else if (state_q == ST_WR_CARRY) begin
			p_we    = 1'b1;
			p_waddr = addr_inb;
			p_wdata = carry_q;
		end
	end

	assign p_re    = (state_q == ST_RD_B) || (state_q == ST_EMIT);
	assign p_raddr = (state_q == ST_EMIT) ? k_q : addr_ij;

	always_ff @(posedge clk) begin
		if (a_we) begin
			mem_a[count_a_q[AW-1:0]] <= limb;
		end
		if (state_q == ST_RD_A) begin
			a_rd_q <= mem_a[i_q];
		end
	end

	always_ff @(posedge clk) begin
		if (b_we) begin
			mem_b[count_b_q[AW-1:0]] <= limb;
		end
		if (state_q == ST_RD_B) begin
			b_rd_q <= mem_b[j_q];
		end
	end

	always_ff @(posedge clk) begin
		if (p_we) begin
			mem_p[p_waddr] <= p_wdata;
		end
		if (p_re) begin
			p_rd_q <= mem_p[p_raddr];
		end
	end

	// The first row has nothing to accumulate onto.
	assign mac_req.go     = (state_q == ST_MAC_GO);
	assign mac_req.x      = a_rd_q;
	assign mac_req.y      = b_rd_q;
	assign mac_req.addend = (i_q == '0) ? '0 : p_rd_q;
	assign mac_req.carry  = carry_q;

	mmu_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mac_req),
		.rsp    (mac_rsp)
	);

	// Sequencer: appends in idle, then rows over A and columns over B, then
	// the result walk. Counts and the overflow flag clear after the walk.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_a_q   <= '0;
			count_b_q   <= '0;
			dropped_q   <= 1'b0;
			zero_q      <= 1'b0;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			carry_q     <= '0;
			strobe_s1   <= 1'b0;
			last_s1     <= 1'b0;
			overflow_s1 <= 1'b0;
			zero_s1     <= 1'b0;
		end else begin
			strobe_s1 <= 1'b0;
			last_s1   <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (op)
							OP_APPEND_A: begin
								if (a_room) begin
									count_a_q <= count_a_q + CW'(1);
								end else begin
									dropped_q <= 1'b1;
								end
							end
							OP_APPEND_B: begin
								if (b_room) begin
									count_b_q <= count_b_q + CW'(1);
								end else begin
									dropped_q <= 1'b1;
								end
							end
							OP_MULTIPLY: begin
								i_q    <= '0;
								k_q    <= '0;
								zero_q <= (count_a_q == '0) || (count_b_q == '0);
								if ((count_a_q == '0) && (count_b_q == '0)) begin
									dropped_q <= 1'b0;
								end else if ((count_a_q == '0) || (count_b_q == '0)) begin
									state_q <= ST_EMIT;
								end else begin
									state_q <= ST_RD_A;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_RD_A: begin
					carry_q <= '0;
					j_q     <= '0;
					state_q <= ST_RD_B;
				end
				ST_RD_B: begin
					state_q <= ST_MAC_GO;
				end
				ST_MAC_GO: begin
					state_q <= ST_MAC_WAIT;
				end
				ST_MAC_WAIT: begin
					if (mac_rsp.done) begin
						carry_q <= mac_rsp.hi;
						if (last_j) begin
							state_q <= ST_WR_CARRY;
						end else begin
							j_q     <= j_q + AW'(1);
							state_q <= ST_RD_B;
						end
					end
				end
				ST_WR_CARRY: begin
					if (last_i) begin
						state_q <= ST_EMIT;
					end else begin
						i_q     <= i_q + AW'(1);
						state_q <= ST_RD_A;
					end
				end
				ST_EMIT: begin
					strobe_s1   <= 1'b1;
					last_s1     <= last_k;
					overflow_s1 <= dropped_q;
					zero_s1     <= zero_q;
					if (last_k) begin
						count_a_q <= '0;
						count_b_q <= '0;
						dropped_q <= 1'b0;
						state_q   <= ST_IDLE;
					end else begin
						k_q <= k_q + PW'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign strobe       = strobe_s1;
	assign last_limb    = last_s1;
	assign overflow     = overflow_s1;
	assign product_limb = zero_s1 ? '0 : p_rd_q;

	a_strobe_from_walk: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_s1 |-> $past(state_q == ST_EMIT))
		else $error("result strobe without a result walk");
	a_last_has_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		last_s1 |-> strobe_s1)
		else $error("last limb marked without a strobe");
	a_mac_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		mac_rsp.done |-> (state_q == ST_MAC_WAIT))
		else $error("multiply-accumulate finished outside its wait state");
	a_counts_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(count_a_q <= CW'(MAX_WORDS)) && (count_b_q <= CW'(MAX_WORDS)))
		else $error("operand count beyond capacity");

endmodule
`default_nettype wire
